// ===== rtl/rrip_pkg.sv =====
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared constants, command codes and types of the RRIP replacement block.
// ----------------------------------------------------------------------------
package rrip_pkg;

  localparam int DEF_SETS = 64;
  localparam int DEF_WAYS = 8;

  localparam int RRPV_W = 2;
  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;

  localparam logic [1:0] CMD_TOUCH  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;
  localparam logic [1:0] CMD_VICTIM = 2'd3;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic start;  // clear running maximum and way counter
    logic step;   // compare one way and advance
  } scan_ctrl_t;

endpackage

// ===== rtl/rrip_row_ram.sv =====
// ----------------------------------------------------------------------------
// rrip_row_ram
// One row per cache set, all way values of the set side by side.
// ----------------------------------------------------------------------------
module rrip_row_ram
  import rrip_pkg::*;
#(
  parameter int DEPTH = DEF_SETS,
  parameter int WIDTH = DEF_WAYS * RRPV_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rrip_max_unit.sv =====
// ----------------------------------------------------------------------------
// rrip_max_unit
// Shared compare unit: walks the ways one per cycle while step is high,
// keeps the largest value seen and the lowest way that holds it.
// ----------------------------------------------------------------------------
module rrip_max_unit
  import rrip_pkg::*;
#(
  parameter int WAYS = DEF_WAYS,
  localparam int WW = $clog2(WAYS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctrl_t        ctrl,
  input  logic [RRPV_W-1:0] value,
  output logic [WW-1:0]     cnt,
  output logic              last,
  output logic [RRPV_W-1:0] max_val,
  output logic [WW-1:0]     max_idx
);

  logic [WW-1:0]     cnt_r,  cnt_nxt;
  logic [RRPV_W-1:0] max_r,  max_nxt;
  logic [WW-1:0]     idx_r,  idx_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    max_nxt = max_r;
    idx_nxt = idx_r;
    if (ctrl.start) begin
      cnt_nxt = '0;
      max_nxt = RRPV_NEAR;
      idx_nxt = '0;
    end else if (ctrl.step) begin
      cnt_nxt = cnt_r + 1'b1;
      // strictly greater: keep the lowest way on a tie
      if (value > max_r) begin
        max_nxt = value;
        idx_nxt = cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    max_r <= max_nxt;
    idx_r <= idx_nxt;
  end

  assign cnt     = cnt_r;
  assign last    = (cnt_r == WW'(WAYS - 1));
  assign max_val = max_r;
  assign max_idx = idx_r;

endmodule

// ===== rtl/rrip_replacement_policy.sv =====
// ----------------------------------------------------------------------------
// rrip_replacement_policy
// SRRIP state keeper: 2-bit re-reference prediction per way of every set.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per command. in_tuser carries the command (touch,
//           insert, invalidate, find victim), in_tdata the set and way.
//   out_* : exactly one beat per command. out_tuser flags a victim answer,
//           out_tdata carries the victim way (zero for other commands).
//   cfg_* : write of the insertion value, taken on any edge out of reset
//           with cfg_wr_en high; write only while the block is idle.
// Sequence: touch, insert and invalidate modify the row and write it back
//   (only for a set and way in range), then hand the result over. Find
//   victim lets the single compare unit walk the ways of the row one per
//   cycle, then writes the aged row back and hands the way over; for a set
//   out of range it skips the walk and answers zero.
//   One command is in flight at a time: a new one is taken only in the idle
//   state, after the result is handed over.
// Reset: a clearing pass writes every row to the distant value, one row a
//   cycle, with in_tready low; configuration writes still land.
// Stall: the result register holds while out_tready is low; a new command
//   may be accepted meanwhile, its result waits until the register frees.
// ----------------------------------------------------------------------------
module rrip_replacement_policy
  import rrip_pkg::*;
#(
  parameter int SETS = DEF_SETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] set_index, [8:6] way_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] victim_way, rest zero
  output logic        out_tuser,  // [0] victim_valid
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data // [1:0] insert_rrpv
);

  localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW    = $clog2(WAYS);
  localparam int ROW_W = WAYS * RRPV_W;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_AGE   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [RRPV_W-1:0] insert_r;

  // captured command
  logic [1:0]        cmd_r;
  logic [AW-1:0]     set_r;
  logic [WW-1:0]     way_r;
  logic              set_ok_r;
  logic              way_ok_r;

  // result in progress and result register
  logic [2:0]        res_way_r, res_way_nxt;
  logic              out_valid_r;
  logic [2:0]        out_way_r;
  logic              out_flag_r;
  logic              out_load;

  // row memory
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  // compare unit
  scan_ctrl_t        scan_ctrl;
  logic [WW-1:0]     scan_cnt;
  logic              scan_last;
  logic [RRPV_W-1:0] scan_max;
  logic [WW-1:0]     scan_idx;

  logic              in_fire;
  logic [5:0]        in_set;
  logic [2:0]        in_way;
  logic [ROW_W-1:0]  row_mod;
  logic [ROW_W-1:0]  row_aged;
  logic [RRPV_W-1:0] new_val;
  logic [RRPV_W-1:0] age_amt;

  assign in_set    = in_tdata[5:0];
  assign in_way    = in_tdata[8:6];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // capture the command on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_tuser;
      set_r    <= AW'(in_set);
      way_r    <= WW'(in_way);
      set_ok_r <= ({26'd0, in_set} < SETS);
      way_ok_r <= ({29'd0, in_way} < WAYS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      insert_r <= RRPV_NEAR;
    end else if (cfg_wr_en) begin
      insert_r <= cfg_wr_data;
    end
  end

  // value written on touch, insert and invalidate
  always_comb begin
    unique case (cmd_r)
      CMD_TOUCH:  new_val = RRPV_NEAR;
      CMD_INSERT: new_val = insert_r;
      CMD_INVAL:  new_val = RRPV_MAX;
      CMD_VICTIM: new_val = RRPV_MAX;
      default:    new_val = RRPV_MAX;
    endcase
  end

  always_comb begin
    row_mod = ram_rdata;
    row_mod[way_r*RRPV_W +: RRPV_W] = new_val;
  end

  // age every way by the same amount so the largest reaches the distant value
  assign age_amt = RRPV_MAX - scan_max;
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_aged[w*RRPV_W +: RRPV_W] = ram_rdata[w*RRPV_W +: RRPV_W] + age_amt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    res_way_nxt     = res_way_r;
    ram_we          = 1'b0;
    ram_waddr       = set_r;
    ram_wdata       = row_mod;
    scan_ctrl.start = 1'b0;
    scan_ctrl.step  = 1'b0;
    out_load        = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = {WAYS{RRPV_MAX}};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        res_way_nxt = 3'd0;
        if (cmd_r == CMD_VICTIM) begin
          if (set_ok_r) begin
            scan_ctrl.start = 1'b1;
            state_nxt       = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          ram_we    = set_ok_r && way_ok_r;
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (scan_last) begin
          state_nxt = ST_AGE;
        end
      end
      ST_AGE: begin
        ram_we      = 1'b1;
        ram_wdata   = row_aged;
        res_way_nxt = 3'(scan_idx);
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ram_re = in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_way_r <= res_way_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_way_r  <= res_way_r;
      out_flag_r <= (cmd_r == CMD_VICTIM);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_way_r};
  assign out_tuser  = out_flag_r;

  rrip_row_ram #(
    .DEPTH (SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(in_set)),
    .rdata (ram_rdata)
  );

  rrip_max_unit #(
    .WAYS (WAYS)
  ) u_max (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (scan_ctrl),
    .value   (ram_rdata[scan_cnt*RRPV_W +: RRPV_W]),
    .cnt     (scan_cnt),
    .last    (scan_last),
    .max_val (scan_max),
    .max_idx (scan_idx)
  );

  // the row memory never reads and writes in one cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("row memory read and write in the same cycle");

  // no result leaves before the clearing pass is over
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result valid during clearing pass");

  // the row is not overwritten while the compare unit walks it
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !ram_we)
    else $error("row written during way walk");

  // the way walk ends in the ageing step
  a_scan_to_age: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && scan_last |=> state_r == ST_AGE)
    else $error("way walk did not end in ageing");

endmodule
